FILE: hw/rtl/npb_pkg.sv
`timescale 1ns / 1ps

package npb_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [7:0]  ALPHA_FF   = 8'hFF;
  localparam logic [15:0] ROUND_HALF = 16'd128;
  localparam logic [7:0]  FULL       = 8'd255;
  localparam logic [3:0]  NIB_MASK   = 4'hF;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] dst;
  } npb_texel_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
    logic        re;
    logic [3:0]  raddr;
  } npb_mem_req_t;

endpackage

FILE: hw/rtl/npb_if.sv
`timescale 1ns / 1ps

interface npb_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  palette_slot;
  logic [31:0] palette_color;
  logic [7:0]  packed_byte;
  logic        low_valid;
  logic        high_valid;
  logic [31:0] dst_low;
  logic [31:0] dst_high;

  modport source (
    output valid, opcode, palette_slot, palette_color, packed_byte,
           low_valid, high_valid, dst_low, dst_high,
    input  ready
  );
  modport sink (
    input  valid, opcode, palette_slot, palette_color, packed_byte,
           low_valid, high_valid, dst_low, dst_high,
    output ready
  );
endinterface

interface npb_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        last;

  modport source (output valid, out_pixel, last, input ready);
  modport sink (input valid, out_pixel, last, output ready);
endinterface

FILE: hw/rtl/nibble_palette_blend_blit.sv
`timescale 1ns / 1ps
// channel  | role   | beat carries
// ---------+--------+---------------------------------------------------------
// item     | sink   | opcode, palette_slot, palette_color, packed_byte,
//          |        | low_valid, high_valid, dst_low, dst_high
// result   | source | out_pixel, last
// cfg      | write  | cfg_wr_en, cfg_wr_data (modulate_color)
//
// One palette read per cycle unless the result stalls: a pixel beat with both
// texels valid reads the low texel, then the high; one result leaves per cycle.
// Each result is registered through s1, s2, s3 and the output register.
// Reset sets modulate_color to all ones; palette contents are undefined.
// A stalled result holds the whole pipeline, including the palette read port.

module nibble_palette_blend_blit
  import npb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  npb_item_if.sink      item,
  npb_result_if.source  result,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data
);

  logic [31:0]  modulate;
  logic         adv;
  npb_mem_req_t mem_req;
  npb_texel_t   texel;
  logic [31:0]  rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulate <= ALL_ONES;
    end else if (cfg_wr_en) begin
      modulate <= cfg_wr_data;
    end
  end

  npb_issue u_issue (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .adv     (adv),
    .mem_req (mem_req),
    .texel   (texel)
  );

  npb_palette_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  npb_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .result   (result),
    .modulate (modulate),
    .texel    (texel),
    .rdata    (rdata),
    .adv      (adv)
  );

endmodule

FILE: hw/rtl/npb_palette_mem.sv
`timescale 1ns / 1ps

module npb_palette_mem
  import npb_pkg::*;
(
  input  logic         clk,
  input  npb_mem_req_t req,
  output logic [31:0]  rdata
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hw/rtl/npb_issue.sv
`timescale 1ns / 1ps

module npb_issue
  import npb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  npb_item_if.sink     item,
  input  logic         adv,
  output npb_mem_req_t mem_req,
  output npb_texel_t   texel
);

  logic        hold_valid;
  logic        h_op;
  logic [3:0]  h_slot;
  logic [31:0] h_color;
  logic [7:0]  h_byte;
  logic        h_lo;
  logic        h_hi;
  logic [31:0] h_dst_lo;
  logic [31:0] h_dst_hi;

  logic emit_lo;
  logic emit_hi;
  logic finishing;
  logic take;

  always_comb begin
    emit_lo   = hold_valid && (h_op == OP_PIXEL) && h_lo;
    emit_hi   = hold_valid && (h_op == OP_PIXEL) && !h_lo && h_hi;
    finishing = (h_op == OP_LOAD) || !(h_lo && h_hi);
    item.ready = !hold_valid || (adv && finishing);
    take      = item.valid && item.ready;

    mem_req.we    = adv && hold_valid && (h_op == OP_LOAD);
    mem_req.waddr = h_slot;
    mem_req.wdata = h_color;
    mem_req.re    = adv;
    mem_req.raddr = h_lo ? (h_byte[3:0] & NIB_MASK) : (h_byte[7:4] & NIB_MASK);

    texel.valid = emit_lo || emit_hi;
    texel.last  = emit_hi || (emit_lo && !h_hi);
    texel.dst   = h_lo ? h_dst_lo : h_dst_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (adv && hold_valid && finishing) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      h_op     <= item.opcode;
      h_slot   <= item.palette_slot;
      h_color  <= item.palette_color;
      h_byte   <= item.packed_byte;
      h_lo     <= item.low_valid;
      h_hi     <= item.high_valid;
      h_dst_lo <= item.dst_low;
      h_dst_hi <= item.dst_high;
    end else if (adv && emit_lo) begin
      h_lo <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/npb_shade.sv
`timescale 1ns / 1ps

module npb_shade
  import npb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  npb_result_if.source result,
  input  logic [31:0]  modulate,
  input  npb_texel_t   texel,
  input  logic [31:0]  rdata,
  output logic         adv
);

  logic        s1_valid;
  logic        s1_last;
  logic [31:0] s1_dst;

  logic        s2_valid;
  logic        s2_last;
  logic        s2_transp;
  logic [31:0] s2_src;
  logic [31:0] s2_dst;

  logic        s3_valid;
  logic        s3_last;
  logic        s3_transp;
  logic        s3_opaque;
  logic [31:0] s3_src;
  logic [31:0] s3_dst;
  logic [15:0] s3_ps [3];
  logic [15:0] s3_pd [3];

  logic        out_valid;
  logic [31:0] out_pixel;
  logic        out_last;

  logic [31:0] modulated;
  logic [15:0] mprod [4];
  logic [7:0]  alpha;
  logic [7:0]  ialpha;
  logic [15:0] ps [3];
  logic [15:0] pd [3];
  logic [15:0] sums [3];
  logic [31:0] blended;
  logic [31:0] pixel_next;

  always_comb begin
    adv = !out_valid || result.ready;
    for (int c = 0; c < 4; c++) begin
      mprod[c] = 16'(rdata[8*c +: 8]) * 16'(modulate[8*c +: 8]) + ROUND_HALF;
      modulated[8*c +: 8] = mprod[c][15:8];
    end
    alpha  = s2_src[31:24];
    ialpha = FULL - alpha;
    for (int c = 0; c < 3; c++) begin
      ps[c] = 16'(s2_src[8*c +: 8]) * 16'(alpha);
      pd[c] = 16'(s2_dst[8*c +: 8]) * 16'(ialpha);
      sums[c] = s3_ps[c] + s3_pd[c] + ROUND_HALF;
      blended[8*c +: 8] = sums[c][15:8];
    end
    blended[31:24] = ALPHA_FF;
    if (s3_transp) begin
      pixel_next = s3_dst;
    end else if (s3_opaque) begin
      pixel_next = s3_src;
    end else begin
      pixel_next = blended;
    end
    result.valid     = out_valid;
    result.out_pixel = out_pixel;
    result.last      = out_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= texel.valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last   <= texel.last;
      s1_dst    <= texel.dst;

      s2_last   <= s1_last;
      s2_dst    <= s1_dst;
      s2_transp <= (rdata[31:24] == 8'd0);
      s2_src    <= (modulate != ALL_ONES) ? modulated : rdata;

      s3_last   <= s2_last;
      s3_dst    <= s2_dst;
      s3_src    <= s2_src;
      s3_transp <= s2_transp;
      s3_opaque <= (alpha == FULL);
      for (int c = 0; c < 3; c++) begin
        s3_ps[c] <= ps[c];
        s3_pd[c] <= pd[c];
      end

      out_pixel <= pixel_next;
      out_last  <= s3_last;
    end
  end

endmodule
